// ===== hw/rtl/ltpe_pkg.sv =====
// Shared types and constants of the local trace pairing engine.
`timescale 1ns / 1ps

package ltpe_pkg;

  // Field layout of the stream payloads
  localparam int unsigned VTX_W       = 6;
  localparam int unsigned FROM_LSB    = 0;
  localparam int unsigned TO_LSB      = 6;
  localparam int unsigned ALLOW_BIT   = 12;
  localparam int unsigned IN_DATA_W   = 16;

  localparam int unsigned ACC_BIT     = 0;
  localparam int unsigned FAULT_BIT   = 1;
  localparam int unsigned EXC_LSB     = 2;
  localparam int unsigned EXC_OUT_W   = 7;
  localparam int unsigned OUT_DATA_W  = 16;

  // Partner count per slot
  localparam int unsigned CNT_W       = 2;
  localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_FULL = 2'd2;

  // Item kinds carried in tuser
  localparam logic MODE_WALK      = 1'b0;
  localparam logic MODE_BACKTRACK = 1'b1;

  // Configuration port
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned DEG_W       = 7;
  localparam logic [0:0]  REG_VERTEX_DEGREE = 1'b0;
  localparam logic [DEG_W-1:0] DEG_RESET    = 7'd1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDF  = 9'b000000010,
    S_RDT  = 9'b000000100,
    S_DEC  = 9'b000001000,
    S_CRD  = 9'b000010000,
    S_CST  = 9'b000100000,
    S_WRF  = 9'b001000000,
    S_WRT  = 9'b010000000,
    S_DONE = 9'b100000000
  } ltpe_state_e;

endpackage

// ===== hw/rtl/ltpe_slot_mem.sv =====
// Neighbour slot memory: partner count and two partners per slot, with valid bits.
`timescale 1ns / 1ps

module ltpe_slot_mem #(
  parameter int unsigned AW = 6,
  parameter int unsigned VW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [ltpe_pkg::CNT_W-1:0] wr_cnt_i,
  input  logic [VW-1:0]              wr_p0_i,
  input  logic [VW-1:0]              wr_p1_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [ltpe_pkg::CNT_W-1:0] rd_cnt_o,
  output logic [VW-1:0]              rd_p0_o,
  output logic [VW-1:0]              rd_p1_o
);
  import ltpe_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned ROW_W = CNT_W + 2 * VW;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [ROW_W-1:0] rd_row_q;
  logic             rd_valid_q;

  // Row storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_cnt_i, wr_p1_i, wr_p0_i};
    end
    rd_row_q <= mem[rd_addr_i];
  end

  // A slot never written reads as an empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_cnt_o = rd_valid_q ? rd_row_q[ROW_W-1 -: CNT_W] : CNT_ZERO;
  assign rd_p1_o  = rd_row_q[2*VW-1 -: VW];
  assign rd_p0_o  = rd_row_q[VW-1:0];

endmodule

// ===== hw/rtl/local_trace_pairing_engine_top.sv =====
// Top level of the local trace pairing engine.
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Content
// s_axis    in   s_axis_tvalid/tready    tuser: mode; tdata: from, to, allow_exception
// m_axis    out  m_axis_tvalid/tready    tdata: accepted, fault, exception_count
// apb       in   psel/penable/pready     vertex_degree at byte address 0
//
// An item passes through the read of both slots, the decision and the hand-over (RDF,
// RDT, DEC, DONE); a self pairing adds the write-back of its slot (WRF), and a pairing
// that writes both slots back adds WRF and WRT. A closing walk first follows the partner
// chain (CRD, CST per step); the single read port of the slot memory paces the walk.
// s_axis_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next item is taken while m_axis is stalled.
// Reset clears all slots at once through per-slot valid bits; no clearing pass.

module local_trace_pairing_engine_top #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // in: [5:0] from_vertex, [11:6] to_vertex, [12] allow_exception, [15:13] zero
  input  logic [ltpe_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // in: [0] mode
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // out: [0] accepted, [1] fault, [8:2] exception_count, [15:9] zero
  output logic [ltpe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ltpe_pkg::PADDR_W-1:0]       paddr,
  input  logic [ltpe_pkg::PDATA_W-1:0]       pwdata,
  output logic [ltpe_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import ltpe_pkg::*;

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned VW = (AW > VTX_W) ? AW : VTX_W;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned DW = ((CW > DEG_W) ? CW : DEG_W) + 2;
  localparam logic [VW:0]   NV      = (VW+1)'(NUM_SLOTS);
  localparam logic [SW-1:0] LAST_ST = SW'(NUM_SLOTS);

  ltpe_state_e state_q, state_d;

  // control state
  logic [DEG_W-1:0] vd_q, vd_d;
  logic [CW-1:0]    full_q, full_d;
  logic [CW-1:0]    exc_q, exc_d;
  logic [VW-1:0]    exv_q, exv_d;
  logic             out_valid_q, out_valid_d;

  // item payload and working registers
  logic             mode_q, mode_d;
  logic             allow_q, allow_d;
  logic [VW-1:0]    f_q, f_d, t_q, t_d;
  logic [CNT_W-1:0] cnt_f_q, cnt_f_d, cnt_t_q, cnt_t_d;
  logic [VW-1:0]    f0_q, f0_d, f1_q, f1_d, t0_q, t0_d, t1_q, t1_d;
  logic [VW-1:0]    cur_q, cur_d, prev_q, prev_d;
  logic [SW-1:0]    steps_q, steps_d;
  logic [1:0]       inc_q, inc_d;
  logic             res_acc_q, res_acc_d, res_fault_q, res_fault_d;
  logic             out_acc_q, out_acc_d, out_fault_q, out_fault_d;
  logic [EXC_OUT_W-1:0] out_exc_q, out_exc_d;

  // slot memory port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CNT_W-1:0] mem_wcnt, rd_cnt;
  logic [VW-1:0]    mem_wp0, mem_wp1, rd_p0, rd_p1;

  ltpe_slot_mem #(.AW(AW), .VW(VW)) u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_cnt_i  (mem_wcnt),
    .wr_p0_i   (mem_wp0),
    .wr_p1_i   (mem_wp1),
    .rd_addr_i (mem_raddr),
    .rd_cnt_o  (rd_cnt),
    .rd_p0_o   (rd_p0),
    .rd_p1_o   (rd_p1)
  );

  // APB: register index sits above the byte offset
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_VERTEX_DEGREE);
  assign prdata = (paddr[PADDR_W-1] == REG_VERTEX_DEGREE) ? PDATA_W'(vd_q) : '0;

  // Decision terms
  logic signed [DW-1:0] deg_s, full2_s;
  logic [DW-1:0]        exc_ext;
  logic                 self_w, in_range, deg_one, closes, late;
  assign self_w   = (f_q == t_q);
  assign in_range = ({1'b0, f_q} < NV) && ({1'b0, t_q} < NV);
  assign exc_ext  = DW'(exc_q);
  assign deg_s    = DW'(vd_q) - exc_ext;
  assign full2_s  = DW'(full_q) + DW'(2);
  assign deg_one  = (deg_s == DW'(1));
  assign closes   = (cnt_f_q == CNT_ONE) && (rd_cnt == CNT_ONE);
  assign late     = allow_q && (full2_s == deg_s - DW'(1));

  // Backtrack: bring the partner being removed to the last place of each slot
  logic          swap_f, swap_t;
  logic [VW-1:0] p0, p1, qi0, qi1, q0, q1, pf0, pf1, pf_last, pt_last;
  logic [1:0]    bt_dfull, wk_inc;
  assign swap_f   = (cnt_f_q == CNT_FULL) && (f0_q == t_q);
  assign p0       = swap_f ? f1_q : f0_q;
  assign p1       = swap_f ? f0_q : f1_q;
  assign qi0      = self_w ? p0 : rd_p0;
  assign qi1      = self_w ? p1 : rd_p1;
  assign swap_t   = (rd_cnt == CNT_FULL) && (qi0 == f_q);
  assign q0       = swap_t ? qi1 : qi0;
  assign q1       = swap_t ? qi0 : qi1;
  assign pf0      = self_w ? q0 : p0;
  assign pf1      = self_w ? q1 : p1;
  assign pf_last  = (cnt_f_q == CNT_ONE) ? pf0 : pf1;
  assign pt_last  = (rd_cnt == CNT_ONE) ? q0 : q1;
  assign bt_dfull = {1'b0, cnt_f_q == CNT_FULL} + {1'b0, rd_cnt == CNT_FULL};
  assign wk_inc   = {1'b0, cnt_f_q == CNT_ONE} + {1'b0, rd_cnt == CNT_ONE};

  // Chain step: first partner that does not lead back
  logic          mv0, mv1;
  logic [VW-1:0] nb;
  assign mv0 = (rd_cnt != CNT_ZERO) && (rd_p0 != prev_q) && ({1'b0, rd_p0} < NV);
  assign mv1 = (rd_cnt == CNT_FULL) && (rd_p1 != prev_q) && ({1'b0, rd_p1} < NV);
  assign nb  = mv0 ? rd_p0 : rd_p1;

  // Memory addressing follows the sequencer
  always_comb begin
    case (state_q)
      S_RDT:   mem_raddr = t_q[AW-1:0];
      S_CRD:   mem_raddr = cur_q[AW-1:0];
      default: mem_raddr = f_q[AW-1:0];
    endcase
    mem_we    = (state_q == S_WRF) || (state_q == S_WRT);
    mem_waddr = (state_q == S_WRT) ? t_q[AW-1:0] : f_q[AW-1:0];
    mem_wcnt  = (state_q == S_WRT) ? cnt_t_q : cnt_f_q;
    mem_wp0   = (state_q == S_WRT) ? t0_q : f0_q;
    mem_wp1   = (state_q == S_WRT) ? t1_q : f1_q;
  end

  always_comb begin
    state_d     = state_q;
    vd_d        = cfg_wr ? pwdata[DEG_W-1:0] : vd_q;
    full_d      = full_q;
    exc_d       = exc_q;
    exv_d       = exv_q;
    mode_d      = mode_q;
    allow_d     = allow_q;
    f_d         = f_q;
    t_d         = t_q;
    cnt_f_d     = cnt_f_q;
    cnt_t_d     = cnt_t_q;
    f0_d        = f0_q;
    f1_d        = f1_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    inc_d       = inc_q;
    res_acc_d   = res_acc_q;
    res_fault_d = res_fault_q;
    out_acc_d   = out_acc_q;
    out_fault_d = out_fault_q;
    out_exc_d   = out_exc_q;
    // drop the result once taken
    out_valid_d = out_valid_q && !m_axis_tready;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = s_axis_tuser;
          f_d     = VW'(s_axis_tdata[FROM_LSB +: VTX_W]);
          t_d     = VW'(s_axis_tdata[TO_LSB +: VTX_W]);
          allow_d = s_axis_tdata[ALLOW_BIT];
          state_d = S_RDF;
        end
      end
      S_RDF: begin
        state_d = S_RDT;
      end
      S_RDT: begin
        // slot of from_vertex arrives
        cnt_f_d = rd_cnt;
        f0_d    = rd_p0;
        f1_d    = rd_p1;
        state_d = S_DEC;
      end
      S_DEC: begin
        // slot of to_vertex is on the read port now
        res_acc_d   = 1'b1;
        res_fault_d = 1'b0;
        inc_d       = 2'd0;
        state_d     = S_DONE;
        if (!in_range) begin
          res_acc_d   = 1'b0;
          res_fault_d = 1'b1;
        end else if (mode_q == MODE_WALK) begin
          if ((cnt_f_q >= CNT_FULL) || (rd_cnt >= CNT_FULL) ||
              (self_w && allow_q && (cnt_f_q != CNT_ZERO))) begin
            res_acc_d   = 1'b0;
            res_fault_d = 1'b1;
          end else if (deg_one) begin
            res_acc_d = 1'b1;
          end else if (self_w && !allow_q) begin
            res_acc_d = 1'b0;
          end else if (self_w) begin
            exc_d   = exc_q + CW'(1);
            full_d  = full_q + CW'(1);
            exv_d   = f_q;
            cnt_f_d = CNT_FULL;
            f0_d    = f_q;
            f1_d    = f_q;
            state_d = S_WRF;
          end else begin
            cnt_f_d = cnt_f_q + CNT_ONE;
            f0_d    = (cnt_f_q == CNT_ZERO) ? t_q : f0_q;
            f1_d    = (cnt_f_q == CNT_ZERO) ? f1_q : t_q;
            cnt_t_d = rd_cnt + CNT_ONE;
            t0_d    = (rd_cnt == CNT_ZERO) ? f_q : rd_p0;
            t1_d    = (rd_cnt == CNT_ZERO) ? rd_p1 : f_q;
            inc_d   = wk_inc;
            if (closes && (full2_s < deg_s) && !late) begin
              cur_d   = f_q;
              prev_d  = f_q;
              steps_d = '0;
              state_d = S_CRD;
            end else begin
              state_d = S_WRF;
            end
          end
        end else begin
          if (deg_one && ((exc_q == '0) || (f_q != exv_q))) begin
            res_acc_d = 1'b1;
          end else if ((cnt_f_q == CNT_ZERO) || (rd_cnt == CNT_ZERO) ||
                       (self_w && (cnt_f_q != CNT_FULL)) ||
                       (pf_last != t_q) || (pt_last != f_q) ||
                       (!self_w && (full_q < CW'(bt_dfull))) ||
                       (self_w && ((exc_q == '0) || (full_q == '0)))) begin
            res_acc_d   = 1'b0;
            res_fault_d = 1'b1;
          end else begin
            if (self_w) begin
              exc_d   = exc_q - CW'(1);
              full_d  = full_q - CW'(1);
              cnt_f_d = CNT_ZERO;
            end else begin
              full_d  = full_q - CW'(bt_dfull);
              cnt_f_d = cnt_f_q - CNT_ONE;
            end
            f0_d    = pf0;
            f1_d    = pf1;
            cnt_t_d = rd_cnt - CNT_ONE;
            t0_d    = q0;
            t1_d    = q1;
            state_d = S_WRF;
          end
        end
      end
      S_CRD: begin
        // reaching to_vertex means the walk would close a cycle early
        if (cur_q == t_q) begin
          res_acc_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          state_d = S_CST;
        end
      end
      S_CST: begin
        if ((mv0 || mv1) && (steps_q != LAST_ST)) begin
          prev_d  = cur_q;
          cur_d   = nb;
          steps_d = steps_q + SW'(1);
          state_d = S_CRD;
        end else begin
          state_d = S_WRF;
        end
      end
      S_WRF: begin
        if ((mode_q == MODE_WALK) && !self_w) begin
          full_d = full_q + CW'(inc_q);
        end
        state_d = self_w ? S_DONE : S_WRT;
      end
      S_WRT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_acc_d   = res_acc_q;
          out_fault_d = res_fault_q;
          out_exc_d   = exc_ext[EXC_OUT_W-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vd_q        <= DEG_RESET;
      full_q      <= '0;
      exc_q       <= '0;
      exv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vd_q        <= vd_d;
      full_q      <= full_d;
      exc_q       <= exc_d;
      exv_q       <= exv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    allow_q     <= allow_d;
    f_q         <= f_d;
    t_q         <= t_d;
    cnt_f_q     <= cnt_f_d;
    cnt_t_q     <= cnt_t_d;
    f0_q        <= f0_d;
    f1_q        <= f1_d;
    t0_q        <= t0_d;
    t1_q        <= t1_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    steps_q     <= steps_d;
    inc_q       <= inc_d;
    res_acc_q   <= res_acc_d;
    res_fault_q <= res_fault_d;
    out_acc_q   <= out_acc_d;
    out_fault_q <= out_fault_d;
    out_exc_q   <= out_exc_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_exc_q, out_fault_q, out_acc_q});

endmodule

// ===== tb/local_trace_pairing_engine_top_tb.sv =====
// Self-checking testbench for the local trace pairing engine: predicted verdicts, random stalls.
`timescale 1ns / 1ps

module local_trace_pairing_engine_top_tb;
  import ltpe_pkg::*;

  localparam int unsigned NV            = 64;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 2 * (NV + 1) + 20;
  localparam int unsigned MAX_REPORTS   = 100;

  // One input item as the generator sees it
  typedef struct packed {
    logic             mode;
    logic [VTX_W-1:0] from_vtx;
    logic [VTX_W-1:0] to_vtx;
    logic             allow;
  } item_t;

  // One predicted result
  typedef struct packed {
    logic                 accepted;
    logic                 fault;
    logic [EXC_OUT_W-1:0] exc_count;
  } verdict_t;

  typedef struct packed {
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
  } pairing_t;

  // Pairing predictor and store of expected verdicts
  class pairing_scoreboard;
    logic [DEG_W-1:0] degree;
    logic [CNT_W-1:0] slot_fill [NV];
    logic [VTX_W-1:0] slot_partner [2*NV];
    int               walk_total;
    int               exc_total;
    logic [VTX_W-1:0] exc_vertex;
    verdict_t         expected_verdicts[$];
    pairing_t         open_pairings[$];
    int unsigned      errors;
    int unsigned      results_seen;

    function new();
      degree = DEG_RESET;
      foreach (slot_fill[i]) slot_fill[i] = CNT_ZERO;
      foreach (slot_partner[i]) slot_partner[i] = '0;
      walk_total   = 0;
      exc_total    = 0;
      exc_vertex   = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Follow the partner chain from start, never stepping straight back.
    function bit chain_links(int unsigned start, int unsigned goal);
      int unsigned here, came_from, nb;
      bit          moved;
      here      = start;
      came_from = start;
      for (int s = 0; s <= NV; s++) begin
        if (here == goal) return 1'b1;
        moved = 1'b0;
        for (int k = 0; k < 2; k++) begin
          if (!moved && k < slot_fill[here]) begin
            nb = 32'(slot_partner[2*here + k]);
            if (nb != came_from) begin
              came_from = here;
              here      = nb;
              moved     = 1'b1;
            end
          end
        end
        if (!moved) return 1'b0;
      end
      return 1'b0;
    endfunction

    function bit predict_walk(int unsigned f, int unsigned t, bit allow);
      int       deg;
      bit       self_pair, closes, late;
      pairing_t pr;
      deg       = int'(degree) - exc_total;
      self_pair = (f == t);
      if (deg == 1) return 1'b1;
      if (self_pair && !allow) return 1'b0;
      if (self_pair) begin
        exc_total++;
        walk_total++;
        exc_vertex = VTX_W'(f);
        deg--;
      end
      closes = (slot_fill[f] == CNT_ONE) && (slot_fill[t] == CNT_ONE);
      if (closes && walk_total + 2 < deg) begin
        late = allow && (walk_total + 2 == deg - 1);
        if (!late && chain_links(f, t)) return 1'b0;
      end
      slot_partner[2*f + slot_fill[f]] = VTX_W'(t);
      slot_fill[f]++;
      slot_partner[2*t + slot_fill[t]] = VTX_W'(f);
      slot_fill[t]++;
      if (!self_pair) walk_total += int'(slot_fill[f] / 2) + int'(slot_fill[t] / 2);
      pr.a = VTX_W'(f);
      pr.b = VTX_W'(t);
      open_pairings.insert(open_pairings.size(), pr);
      return 1'b1;
    endfunction

    // Returns 0 on a fault, 1 otherwise.
    function bit predict_backtrack(int unsigned f, int unsigned t);
      int               deg, nfull, nexc;
      int unsigned      cf, ct;
      logic [VTX_W-1:0] lf [2];
      logic [VTX_W-1:0] lt [2];
      logic [VTX_W-1:0] tmp;
      deg = int'(degree) - exc_total;
      if (deg == 1 && (exc_total == 0 || f != exc_vertex)) return 1'b1;
      cf = 32'(slot_fill[f]);
      ct = 32'(slot_fill[t]);
      if (cf == 0 || ct == 0) return 1'b0;
      if (f == t && cf < 2) return 1'b0;
      lf[0] = slot_partner[2*f];
      lf[1] = slot_partner[2*f + 1];
      lt[0] = slot_partner[2*t];
      lt[1] = slot_partner[2*t + 1];
      // Swap so that the partner being removed sits last; a self pairing
      // swaps the one list twice.
      if (cf == 2 && lf[0] == t) begin
        tmp = lf[0]; lf[0] = lf[1]; lf[1] = tmp;
      end
      if (f == t) begin
        if (ct == 2 && lf[0] == f) begin
          tmp = lf[0]; lf[0] = lf[1]; lf[1] = tmp;
        end
        if (lf[cf-1] != t || lf[ct-1] != f) return 1'b0;
      end else begin
        if (ct == 2 && lt[0] == f) begin
          tmp = lt[0]; lt[0] = lt[1]; lt[1] = tmp;
        end
        if (lf[cf-1] != t || lt[ct-1] != f) return 1'b0;
      end
      nfull = walk_total;
      nexc  = exc_total;
      if (f != t) begin
        nfull -= int'(cf / 2 + ct / 2);
      end else begin
        nexc--;
        nfull--;
      end
      if (nfull < 0 || nexc < 0) return 1'b0;
      walk_total = nfull;
      exc_total  = nexc;
      slot_partner[2*f]     = lf[0];
      slot_partner[2*f + 1] = lf[1];
      if (f != t) begin
        slot_partner[2*t]     = lt[0];
        slot_partner[2*t + 1] = lt[1];
      end
      slot_fill[f]--;
      slot_fill[t]--;
      for (int i = open_pairings.size() - 1; i >= 0; i--) begin
        if ((open_pairings[i].a == f && open_pairings[i].b == t) ||
            (open_pairings[i].a == t && open_pairings[i].b == f)) begin
          open_pairings.delete(i);
          break;
        end
      end
      return 1'b1;
    endfunction

    // Note an accepted input transfer and queue its verdict.
    function void note_item(item_t it);
      verdict_t v;
      v = '0;
      if (it.mode == MODE_WALK) begin
        if (slot_fill[it.from_vtx] >= CNT_FULL || slot_fill[it.to_vtx] >= CNT_FULL)
          v.fault = 1'b1;
        else if (it.from_vtx == it.to_vtx && it.allow && slot_fill[it.from_vtx] != CNT_ZERO)
          v.fault = 1'b1;
        else
          v.accepted = predict_walk(32'(it.from_vtx), 32'(it.to_vtx), it.allow);
      end else begin
        if (predict_backtrack(32'(it.from_vtx), 32'(it.to_vtx))) v.accepted = 1'b1;
        else v.fault = 1'b1;
      end
      v.exc_count = EXC_OUT_W'(exc_total);
      expected_verdicts.insert(expected_verdicts.size(), v);
    endfunction

    task report_mismatch(string what, int got, int want);
      if (errors < MAX_REPORTS)
        $display("[%0t] result %0d: %s mismatch, got %0d, want %0d",
                 $time, results_seen, what, got, want);
      errors++;
    endtask

    // Check one output transfer against the oldest verdict.
    task check_result(logic [OUT_DATA_W-1:0] d);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result", int'(d), -1);
      end else begin
        want = expected_verdicts.pop_front();
        if (d[ACC_BIT] !== want.accepted)
          report_mismatch("accepted", int'(d[ACC_BIT]), int'(want.accepted));
        if (d[FAULT_BIT] !== want.fault)
          report_mismatch("fault", int'(d[FAULT_BIT]), int'(want.fault));
        if (d[EXC_LSB +: EXC_OUT_W] !== want.exc_count)
          report_mismatch("exception_count", int'(d[EXC_LSB +: EXC_OUT_W]),
                          int'(want.exc_count));
      end
      results_seen++;
    endtask
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic                    s_axis_tuser  = MODE_WALK;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [PADDR_W-1:0]      paddr         = '0;
  logic [PDATA_W-1:0]      pwdata        = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 60;
  int unsigned cycle_count = 0;

  pairing_scoreboard sb = new();

  local_trace_pairing_engine_top #(.NUM_SLOTS(NV)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Hard stop should the block hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: check each output transfer, then decide the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic item_t make_item(logic mode, int unsigned f, int unsigned t, logic allow);
    item_t it;
    it.mode     = mode;
    it.from_vtx = VTX_W'(f);
    it.to_vtx   = VTX_W'(t);
    it.allow    = allow;
    return it;
  endfunction

  // Mostly well-formed walks and backtracks of the latest pairing over a window
  // of slots; the rest is noise over the full field ranges.
  function automatic item_t next_item(int unsigned base, int unsigned span);
    pairing_t    last;
    int unsigned roll, f, t;
    roll = $urandom_range(99);
    if (roll < 12)
      return make_item(1'($urandom_range(1)), $urandom_range(NV-1), $urandom_range(NV-1),
                       1'($urandom_range(1)));
    if (sb.open_pairings.size() != 0 && roll < 45) begin
      last = sb.open_pairings[$];
      if ($urandom_range(1))
        return make_item(MODE_BACKTRACK, 32'(last.b), 32'(last.a), 1'($urandom_range(1)));
      return make_item(MODE_BACKTRACK, 32'(last.a), 32'(last.b), 1'($urandom_range(1)));
    end
    if ($urandom_range(99) < 8) begin
      for (int k = 0; k < 16; k++) begin
        f = (base + $urandom_range(span - 1)) % NV;
        if (sb.slot_fill[f] == CNT_ZERO)
          return make_item(MODE_WALK, f, f, $urandom_range(99) < 80);
      end
    end
    for (int k = 0; k < 16; k++) begin
      f = (base + $urandom_range(span - 1)) % NV;
      t = (base + $urandom_range(span - 1)) % NV;
      if (f != t && sb.slot_fill[f] < CNT_FULL && sb.slot_fill[t] < CNT_FULL)
        return make_item(MODE_WALK, f, t, $urandom_range(99) < 35);
    end
    if (sb.open_pairings.size() != 0) begin
      last = sb.open_pairings[$];
      return make_item(MODE_BACKTRACK, 32'(last.a), 32'(last.b), 1'b0);
    end
    return make_item(MODE_WALK, f, t, 1'($urandom_range(1)));
  endfunction

  // Present one item, idling first at random; leave tvalid high after the transfer.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {3'b000, it.allow, it.to_vtx, it.from_vtx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_degree(int unsigned value);
    drain_results();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_VERTEX_DEGREE);
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.degree = DEG_W'(value);
  endtask

  task automatic run_phase(int unsigned deg, int unsigned base, int unsigned span,
                           int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    write_degree(deg);
    for (int n = 0; n < count; n++) begin
      // Run a stretch without any idling on either side.
      if (n >= 40 && n < 55) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
      end
      if (n == count / 2) drain_results();
      send_item(next_item(base, span));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Degree one out of reset: both kinds pass through untouched.
    send_item(make_item(MODE_WALK, 0, NV-1, 1'b1));
    send_item(make_item(MODE_BACKTRACK, NV-1, 0, 1'b0));

    write_degree(6);
    send_item(make_item(MODE_WALK, 0, 1, 1'b0));
    send_item(make_item(MODE_WALK, 1, 2, 1'b0));
    send_item(make_item(MODE_WALK, 2, 3, 1'b0));
    send_item(make_item(MODE_WALK, 3, 0, 1'b0));      // closes the cycle too early
    send_item(make_item(MODE_WALK, 3, 4, 1'b0));
    send_item(make_item(MODE_WALK, 4, 0, 1'b0));      // early close, no exception
    send_item(make_item(MODE_WALK, 4, 0, 1'b1));      // late close allowed
    send_item(make_item(MODE_WALK, 1, 5, 1'b0));      // full slot
    send_item(make_item(MODE_WALK, 5, 5, 1'b0));      // self pairing not allowed
    send_item(make_item(MODE_WALK, 10, 11, 1'b0));
    send_item(make_item(MODE_WALK, 10, 10, 1'b1));    // self pairing of an occupied slot
    send_item(make_item(MODE_WALK, 5, 5, 1'b1));      // exception
    send_item(make_item(MODE_BACKTRACK, 20, 21, 1'b0)); // empty slots
    send_item(make_item(MODE_BACKTRACK, 11, 11, 1'b0)); // self with one entry
    send_item(make_item(MODE_BACKTRACK, 0, 2, 1'b0));   // partners do not match
    send_item(make_item(MODE_BACKTRACK, 5, 5, 1'b1));
    send_item(make_item(MODE_BACKTRACK, 10, 11, 1'b0));
    send_item(make_item(MODE_BACKTRACK, 0, 4, 1'b0));
    send_item(make_item(MODE_BACKTRACK, 1, 0, 1'b0));   // needs a partner swap
    send_item(make_item(MODE_WALK, NV-1, NV-2, 1'b1));
    send_item(make_item(MODE_BACKTRACK, NV-2, NV-1, 1'b1));

    // Sender light, receiver heavy; then the reverse; then no idling.
    run_phase(8,       0,  8, 95, 22, 60);
    run_phase(NV,      0, NV, 95, 22, 60);
    run_phase(3,      60,  4, 95, 22, 60);
    run_phase(16,     40, 16, 95, 60, 22);
    run_phase(1,       0,  8, 95, 60, 22);
    run_phase(5,      30,  6, 95, 60, 22);
    run_phase(NV,     10, 20, 95, 0, 0);
    run_phase(2,       0,  3, 95, 0, 0);
    run_phase(12,     50, 12, 95, 0, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
